### hdl/ustc_pkg.sv
// Shared constants, types and month table for the Unix stamp to calendar converter.
package ustc_pkg;

    localparam int unsigned STAMP_W = 32;

    // Exact reciprocals: q = (x * M) >> K for every x below 2**N.
    localparam logic [30:0] DIV15_M34   = 31'd1145324613;  // x < 2**30, K = 34
    localparam logic [25:0] DIV15_M29   = 26'd35791395;    // x < 2**25, K = 29
    localparam logic [18:0] DIV3_M20    = 19'd349526;      // x < 2**18, K = 20
    localparam logic [16:0] DIV1461_M27 = 17'd91868;       // x < 2**16, K = 27
    localparam logic [16:0] DIV365_M25  = 17'd91930;       // x < 2**16, K = 25

    localparam logic [8:0]  OFFSET_MIN  = 9'd480;
    localparam logic [10:0] CYCLE_DAYS  = 11'd1461;
    localparam logic [8:0]  YEAR_DAYS   = 9'd365;
    localparam logic [8:0]  FEB29_DOY   = 9'd60;

    localparam int unsigned N_MONTH_ENDS = 11;

    // Last day of year for January .. November, common year.
    localparam logic [8:0] MONTH_END [0:N_MONTH_ENDS-1] = '{
        9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    typedef struct packed {
        logic [5:0]  sec;
        logic [5:0]  minute;
        logic [20:0] hours;   // local hours since epoch
        logic [15:0] days;    // local days since epoch
    } t_time;

    typedef struct packed {
        logic [5:0]        sec;
        logic [5:0]        minute;
        logic [4:0]        hour;
        logic signed [7:0] year;
        logic [3:0]        month;
        logic [4:0]        mday;
    } t_cal;

    // Days before the month, common year; index 0 is January.
    function automatic logic [8:0] month_start(input logic [3:0] idx);
        logic [8:0] v;
        case (idx)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd59;
            4'd3:    v = 9'd90;
            4'd4:    v = 9'd120;
            4'd5:    v = 9'd151;
            4'd6:    v = 9'd181;
            4'd7:    v = 9'd212;
            4'd8:    v = 9'd243;
            4'd9:    v = 9'd273;
            4'd10:   v = 9'd304;
            4'd11:   v = 9'd334;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

### hdl/ustc_if.sv
// Valid/ready channel interfaces for the timestamp input and the calendar output.
interface ustc_stamp_if;
    logic                              valid;
    logic                              ready;
    logic [ustc_pkg::STAMP_W-1:0]      unix_seconds;

    modport source (output valid, output unix_seconds, input ready);
    modport sink   (input valid, input unix_seconds, output ready);
endinterface

interface ustc_cal_if;
    logic              valid;
    logic              ready;
    logic [5:0]        sec_of_minute;
    logic [5:0]        min_of_hour;
    logic [4:0]        hour_of_day;
    logic signed [7:0] year_since_2000;
    logic [3:0]        month_number;
    logic [4:0]        day_of_month;

    modport source (output valid, output sec_of_minute, output min_of_hour,
                    output hour_of_day, output year_since_2000, output month_number,
                    output day_of_month, input ready);
    modport sink   (input valid, input sec_of_minute, input min_of_hour,
                    input hour_of_day, input year_since_2000, input month_number,
                    input day_of_month, output ready);
endinterface

### hdl/unix_stamp_to_calendar.sv
// Top level: Unix seconds to local (UTC+8) calendar date and time, seven-stage pipeline.
//
//  Port     Dir   Contents
//  -------  ----  ---------------------------------------------------------
//  i_ts     in    unix_seconds[31:0]
//  o_cal    out   sec, min, hour, year_since_2000 (signed), month, day
//
//  One transaction per cycle while the output is not held.
//  The depth is set by the chain of reciprocal multiplies (/60, /60, /24,
//  /1461, /365) followed by the month table compare.
//  Reset clears all valid bits; payload registers are not reset.
//  A held output stalls every stage at once; i_ts.ready drops with it.
module unix_stamp_to_calendar (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ustc_stamp_if.sink  i_ts,
    ustc_cal_if.source  o_cal
);

    logic            w_en;
    logic            w_time_v;
    ustc_pkg::t_time w_time;
    logic            w_cal_v;
    ustc_pkg::t_cal  w_cal;

    assign w_en       = !w_cal_v || o_cal.ready;
    assign i_ts.ready = w_en;

    ustc_time u_time (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_ts.valid),
        .i_secs  (i_ts.unix_seconds),
        .o_valid (w_time_v),
        .o_time  (w_time)
    );

    ustc_date u_date (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_time_v),
        .i_time  (w_time),
        .o_valid (w_cal_v),
        .o_cal   (w_cal)
    );

    assign o_cal.valid           = w_cal_v;
    assign o_cal.sec_of_minute   = w_cal.sec;
    assign o_cal.min_of_hour     = w_cal.minute;
    assign o_cal.hour_of_day     = w_cal.hour;
    assign o_cal.year_since_2000 = w_cal.year;
    assign o_cal.month_number    = w_cal.month;
    assign o_cal.day_of_month    = w_cal.mday;

endmodule

### hdl/ustc_time.sv
// Stages 1-3: seconds, minutes, local hour count and day count from the raw stamp.
module ustc_time (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [ustc_pkg::STAMP_W-1:0] i_secs,
    output logic                         o_valid,
    output ustc_pkg::t_time              o_time
);

    logic        r_v1, r_v2, r_v3;
    logic [31:0] r_s1;
    logic [26:0] r_mins1, r_mins2;
    logic [5:0]  r_sec2, r_sec3, r_min3;
    logic [20:0] r_hours2, r_hours3;
    logic [15:0] r_days3;

    logic [60:0] n_p1;
    logic [26:0] n_mins1;
    logic [5:0]  n_sec2;
    logic [26:0] n_a2;
    logic [50:0] n_p2;
    logic [20:0] n_hours2;
    logic [20:0] n_hq3;
    logic [5:0]  n_min3;
    logic [37:0] n_p3;
    logic [15:0] n_days3;

    // s / 60 = (s >> 2) / 15
    assign n_p1    = 61'(i_secs[31:2]) * 61'(ustc_pkg::DIV15_M34);
    assign n_mins1 = n_p1[60:34];

    assign n_sec2   = 6'(r_s1 - 32'(r_mins1) * 32'd60);
    assign n_a2     = r_mins1 + 27'(ustc_pkg::OFFSET_MIN);
    assign n_p2     = 51'(n_a2[26:2]) * 51'(ustc_pkg::DIV15_M29);
    assign n_hours2 = n_p2[49:29];

    // offset is a whole number of hours, so mins / 60 = hours - 8
    assign n_hq3   = r_hours2 - 21'd8;
    assign n_min3  = 6'(r_mins2 - 27'(n_hq3) * 27'd60);
    assign n_p3    = 38'(r_hours2[20:3]) * 38'(ustc_pkg::DIV3_M20);
    assign n_days3 = n_p3[35:20];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1     <= i_secs;
            r_mins1  <= n_mins1;
            r_sec2   <= n_sec2;
            r_mins2  <= r_mins1;
            r_hours2 <= n_hours2;
            r_sec3   <= r_sec2;
            r_min3   <= n_min3;
            r_hours3 <= r_hours2;
            r_days3  <= n_days3;
        end
    end

    assign o_valid       = r_v3;
    assign o_time.sec    = r_sec3;
    assign o_time.minute = r_min3;
    assign o_time.hours  = r_hours3;
    assign o_time.days   = r_days3;

endmodule

### hdl/ustc_date.sv
// Stages 4-7: hour of day, four-year cycle correction, year, month and day.
module ustc_date (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  ustc_pkg::t_time i_time,
    output logic            o_valid,
    output ustc_pkg::t_cal  o_cal
);

    logic        r_v4, r_v5, r_v6, r_v7;
    logic [5:0]  r_sec4, r_sec5, r_sec6;
    logic [5:0]  r_min4, r_min5, r_min6;
    logic [4:0]  r_hour4, r_hour5, r_hour6;
    logic [15:0] r_days4;
    logic [5:0]  r_c4, r_c5;
    logic        r_dec31_5, r_dec31_6;
    logic [15:0] r_d2_5;
    logic [7:0]  r_q5;
    logic [7:0]  r_year6;
    logic        r_feb29_6;
    logic [8:0]  r_doy6;
    ustc_pkg::t_cal r_out7;

    logic [4:0]  n_hour4;
    logic [15:0] n_a4;
    logic [32:0] n_p4;
    logic [5:0]  n_c4;
    logic [15:0] n_r5;
    logic [15:0] n_d2_5;
    logic [32:0] n_p5;
    logic [7:0]  n_q5;
    logic [8:0]  n_doy0_6;
    logic [8:0]  n_doy6;
    logic        n_leap6;
    logic [7:0]  n_year6;
    logic [3:0]  n_midx7;
    logic [8:0]  n_mday7;
    ustc_pkg::t_cal n_out7;

    assign n_hour4 = 5'(i_time.hours - 21'(i_time.days) * 21'd24);
    assign n_a4    = i_time.days + 16'(ustc_pkg::YEAR_DAYS);
    assign n_p4    = 33'(n_a4) * 33'(ustc_pkg::DIV1461_M27);
    assign n_c4    = n_p4[32:27];

    // remainder of (days + 365) / 1461 at its top value marks 31 December of a leap year
    assign n_r5   = 16'(r_days4 + 16'(ustc_pkg::YEAR_DAYS)
                        - 16'(r_c4) * 16'(ustc_pkg::CYCLE_DAYS));
    assign n_d2_5 = r_days4 - 16'(r_c4);
    assign n_p5   = 33'(n_d2_5) * 33'(ustc_pkg::DIV365_M25);
    assign n_q5   = n_p5[32:25];

    assign n_doy0_6 = 9'(r_d2_5 - 16'(r_q5) * 16'(ustc_pkg::YEAR_DAYS)) + 9'd1;
    assign n_leap6  = (r_q5[1:0] == 2'd2);
    assign n_doy6   = (n_leap6 && n_doy0_6 > ustc_pkg::FEB29_DOY) ? n_doy0_6 - 9'd1
                                                                : n_doy0_6;
    assign n_year6  = r_dec31_5 ? 8'({r_c5, 2'b00}) - 8'd28 : r_q5 - 8'd30;

    always_comb begin
        n_midx7 = '0;
        for (int i = 0; i < ustc_pkg::N_MONTH_ENDS; i++) begin
            if (ustc_pkg::MONTH_END[i] < r_doy6) begin
                n_midx7 = n_midx7 + 4'd1;
            end
        end
        n_mday7 = r_doy6 - ustc_pkg::month_start(n_midx7);

        n_out7.sec    = r_sec6;
        n_out7.minute = r_min6;
        n_out7.hour   = r_hour6;
        n_out7.year   = r_year6;
        if (r_dec31_6) begin
            n_out7.month = 4'd12;
            n_out7.mday  = 5'd31;
        end else if (r_feb29_6) begin
            n_out7.month = 4'd2;
            n_out7.mday  = 5'd29;
        end else begin
            n_out7.month = n_midx7 + 4'd1;
            n_out7.mday  = n_mday7[4:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else if (i_en) begin
            r_v4 <= i_valid;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sec4    <= i_time.sec;
            r_min4    <= i_time.minute;
            r_hour4   <= n_hour4;
            r_days4   <= i_time.days;
            r_c4      <= n_c4;

            r_sec5    <= r_sec4;
            r_min5    <= r_min4;
            r_hour5   <= r_hour4;
            r_c5      <= r_c4;
            r_dec31_5 <= (n_r5 == 16'(ustc_pkg::CYCLE_DAYS - 11'd1));
            r_d2_5    <= n_d2_5;
            r_q5      <= n_q5;

            r_sec6    <= r_sec5;
            r_min6    <= r_min5;
            r_hour6   <= r_hour5;
            r_year6   <= n_year6;
            r_dec31_6 <= r_dec31_5;
            r_feb29_6 <= !r_dec31_5 && n_leap6 && (n_doy0_6 == ustc_pkg::FEB29_DOY);
            r_doy6    <= n_doy6;

            r_out7    <= n_out7;
        end
    end

    assign o_valid = r_v7;
    assign o_cal   = r_out7;

endmodule

### hdl/ustc_checker.sv
// Port-level checks for unix_stamp_to_calendar, attached by bind.
module ustc_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [5:0]        i_sec,
    input logic [5:0]        i_min,
    input logic [4:0]        i_hour,
    input logic signed [7:0] i_year,
    input logic [3:0]        i_month,
    input logic [4:0]        i_mday
);

    // nothing valid right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // input side is ready exactly when the output register can move
    a_ready_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready does not follow output stall");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_sec) && $stable(i_min)
            && $stable(i_hour) && $stable(i_year) && $stable(i_month) && $stable(i_mday))
        else $error("stalled result changed");

    a_fields_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_sec < 6'd60 && i_min < 6'd60 && i_hour < 5'd24
            && i_month >= 4'd1 && i_month <= 4'd12 && i_mday >= 5'd1
            && i_year >= -8'sd30 && i_year <= 8'sd106)
        else $error("calendar field out of range");

endmodule

bind unix_stamp_to_calendar ustc_checker u_ustc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_ts.ready),
    .i_out_valid (o_cal.valid),
    .i_out_ready (o_cal.ready),
    .i_sec       (o_cal.sec_of_minute),
    .i_min       (o_cal.min_of_hour),
    .i_hour      (o_cal.hour_of_day),
    .i_year      (o_cal.year_since_2000),
    .i_month     (o_cal.month_number),
    .i_mday      (o_cal.day_of_month)
);

### sim/ustc_checker.sv
// Scoreboard for the Unix stamp to calendar converter: predicts and checks every result.
module ustc_scoreboard (
    input  logic   i_clk,
    input  logic   i_rst_n,
    ustc_stamp_if  i_ts,
    ustc_cal_if    i_cal,
    output int     o_fail_count,
    output int     o_pending
);

    localparam int unsigned MAX_REPORTS    = 10;
    localparam int unsigned SEC_PER_MIN    = 60;
    localparam int unsigned MIN_PER_HOUR   = 60;
    localparam int unsigned HOUR_PER_DAY   = 24;
    localparam int unsigned LEAP_YEAR_DAYS = 366;
    localparam int unsigned EPOCH_YEAR_OFS = 30;
    localparam int unsigned MONTH_DAYS [0:11] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    ustc_pkg::t_cal expected_cal [$];
    int             fail_count;

    // Local (UTC+8) calendar fields of a Unix stamp; every year divisible by 4 is leap.
    function automatic ustc_pkg::t_cal local_calendar(input logic [31:0] stamp);
        int unsigned    mins;
        int unsigned    hrs;
        int unsigned    days;
        int unsigned    years;
        int unsigned    doy;
        int unsigned    m;
        logic           leap;
        ustc_pkg::t_cal c;
        c.sec    = 6'(stamp % SEC_PER_MIN);
        mins     = stamp / SEC_PER_MIN;
        c.minute = 6'(mins % MIN_PER_HOUR);
        hrs      = (mins + ustc_pkg::OFFSET_MIN) / MIN_PER_HOUR;
        c.hour   = 5'(hrs % HOUR_PER_DAY);
        days     = hrs / HOUR_PER_DAY;
        if ((days + LEAP_YEAR_DAYS) % ustc_pkg::CYCLE_DAYS == 0) begin
            // Dec 31 of a leap year
            c.year  = 8'(int'(days / LEAP_YEAR_DAYS) - int'(EPOCH_YEAR_OFS));
            c.month = 4'd12;
            c.mday  = 5'd31;
        end else begin
            days   = days - (days + ustc_pkg::YEAR_DAYS) / ustc_pkg::CYCLE_DAYS;
            years  = days / ustc_pkg::YEAR_DAYS;
            c.year = 8'(int'(years) - int'(EPOCH_YEAR_OFS));
            leap   = ((years + 2) % 4) == 0;
            doy    = days % ustc_pkg::YEAR_DAYS + 1;
            if (leap && doy == ustc_pkg::FEB29_DOY) begin
                c.month = 4'd2;
                c.mday  = 5'd29;
            end else begin
                if (leap && doy > ustc_pkg::FEB29_DOY) begin
                    doy--;
                end
                m = 0;
                while (m < 11 && MONTH_DAYS[m] < doy) begin
                    doy -= MONTH_DAYS[m];
                    m++;
                end
                c.month = 4'(m + 1);
                c.mday  = 5'(doy);
            end
        end
        return c;
    endfunction

    always @(posedge i_clk) begin : watch
        ustc_pkg::t_cal want;
        ustc_pkg::t_cal got;
        if (!i_rst_n) begin
            expected_cal.delete();
            fail_count = 0;
        end else begin
            if (i_ts.valid && i_ts.ready) begin
                expected_cal.push_back(local_calendar(i_ts.unix_seconds));
            end
            if (i_cal.valid && i_cal.ready) begin
                got.sec    = i_cal.sec_of_minute;
                got.minute = i_cal.min_of_hour;
                got.hour   = i_cal.hour_of_day;
                got.year   = i_cal.year_since_2000;
                got.month  = i_cal.month_number;
                got.mday   = i_cal.day_of_month;
                if (expected_cal.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("unexpected calendar transaction: %0d-%0d-%0d %0d:%0d:%0d",
                                 got.year, got.month, got.mday, got.hour, got.minute, got.sec);
                    end
                end else begin
                    want = expected_cal.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $display({"calendar mismatch: expected %0d-%0d-%0d %0d:%0d:%0d,",
                                      " got %0d-%0d-%0d %0d:%0d:%0d"},
                                     want.year, want.month, want.mday,
                                     want.hour, want.minute, want.sec,
                                     got.year, got.month, got.mday,
                                     got.hour, got.minute, got.sec);
                        end
                    end
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_cal.size();
    end

endmodule

### sim/tb_unix_stamp_to_calendar.sv
// Testbench top: drives timestamps and output stalls into the converter and gives the verdict.
module tb_unix_stamp_to_calendar;

    localparam int unsigned N_RANDOM      = 700;
    localparam int unsigned BURST_START   = 300;
    localparam int unsigned BURST_END     = 450;
    localparam int unsigned HOLD_CYCLES   = 250;
    localparam int unsigned DRAIN_CYCLES  = 20;
    localparam int unsigned SEC_PER_DAY   = 86400;
    localparam int unsigned UTC_OFS_SEC   = 28800;
    localparam int unsigned LEAP_DEC31    = 1095;   // local day of 1972-12-31
    localparam int unsigned N_LEAP_CYCLES = 33;
    localparam int unsigned LAST_DAY      = 49709;

    localparam logic [31:0] EDGE_STAMPS [0:5] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
        32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA
    };
    // Dec 31, Feb 29/Mar 1, leap Dec 31, Jan 1, 2000 Feb 29 and Dec 31, 2100 leap days
    localparam int unsigned EDGE_DAYS [0:8] = '{
        364, 789, 790, 1095, 1096, 11016, 11322, 47541, 47542
    };

    logic i_clk;
    logic i_rst_n;
    logic hold_req;
    int   fail_count;
    int   pending;

    ustc_stamp_if ts_ch ();
    ustc_cal_if   cal_ch ();

    unix_stamp_to_calendar dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ts    (ts_ch),
        .o_cal   (cal_ch)
    );

    ustc_scoreboard u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ts         (ts_ch),
        .i_cal        (cal_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Unix stamp of a local day and second of that day
    function automatic logic [31:0] stamp_at(input int unsigned day, input int unsigned sod);
        longint t;
        t = longint'(day) * SEC_PER_DAY + sod - UTC_OFS_SEC;
        if (t < 0 || t > 64'hFFFF_FFFF) return $urandom;
        return t[31:0];
    endfunction

    task automatic send_stamp(input logic [31:0] stamp, input int unsigned gap);
        if (gap > 0) begin
            ts_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        ts_ch.valid        <= 1'b1;
        ts_ch.unix_seconds <= stamp;
        @(posedge i_clk);
        while (!ts_ch.ready) @(posedge i_clk);
    endtask

    // Output side: random stalls, one long hold-off while the input sends a back-to-back burst
    initial begin : sink_side
        bit          hold_done;
        int unsigned gap;
        hold_done = 1'b0;
        cal_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                cal_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            cal_ch.ready <= 1'b1;
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(100, 200)) @(posedge i_clk);
            end else begin
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            gap = idle_len();
            if (gap > 0) begin
                cal_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    initial begin : source_side
        int unsigned r;
        int unsigned gap;
        logic [31:0] stamp;
        i_rst_n            <= 1'b0;
        hold_req           <= 1'b0;
        ts_ch.valid        <= 1'b0;
        ts_ch.unix_seconds <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (EDGE_STAMPS[k]) begin
            send_stamp(EDGE_STAMPS[k], idle_len());
        end
        foreach (EDGE_DAYS[k]) begin
            send_stamp(stamp_at(EDGE_DAYS[k], 0), idle_len());
            send_stamp(stamp_at(EDGE_DAYS[k], SEC_PER_DAY - 1), idle_len());
        end

        for (int unsigned n = 0; n < N_RANDOM; n++) begin
            if (n == BURST_START) begin
                hold_req <= 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 60) begin
                stamp = $urandom;
            end else if (r < 80) begin
                // around the last day of a leap year
                stamp = stamp_at(LEAP_DEC31
                                 + ustc_pkg::CYCLE_DAYS * $urandom_range(0, N_LEAP_CYCLES)
                                 + $urandom_range(0, 4) - 2,
                                 $urandom_range(0, SEC_PER_DAY - 1));
            end else if ($urandom_range(0, 1) == 1) begin
                stamp = stamp_at($urandom_range(1, LAST_DAY), $urandom_range(0, 3));
            end else begin
                stamp = stamp_at($urandom_range(1, LAST_DAY),
                                 SEC_PER_DAY - 1 - $urandom_range(0, 3));
            end
            gap = (n >= BURST_START && n < BURST_END) ? 0 : idle_len();
            send_stamp(stamp, gap);
        end
        ts_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
